[hdl/swrf_pkg.sv]
package swrf_pkg;

  localparam int unsigned GRAVITY_RESET      = 642908;
  localparam int unsigned HALF_GRAVITY_RESET = 321454;

  // Integer square root of a 56-bit radicand gives a 28-bit root.
  localparam int RADICAND_W = 56;
  localparam int ROOT_W     = 28;
  localparam int SQRT_STEPS = 4;

  // Widths of the exact intermediate sums.
  localparam int MASS_W = 65;
  localparam int DIFF_W = 65;
  localparam int SUM_W  = 99;

  // Register select on paddr[2].
  localparam logic REG_GRAVITY      = 1'b0;
  localparam logic REG_HALF_GRAVITY = 1'b1;

  typedef struct packed {
    logic signed [31:0] left_depth;
    logic signed [31:0] left_vel_normal;
    logic signed [31:0] left_vel_tangent;
    logic signed [31:0] right_depth;
    logic signed [31:0] right_vel_normal;
    logic signed [31:0] right_vel_tangent;
  } request_t;

  typedef struct packed {
    logic signed [47:0] mass_flux;
    logic signed [47:0] normal_momentum_flux;
    logic signed [47:0] tangent_momentum_flux;
    logic [31:0]        max_wave_speed;
  } result_t;

  // Everything of one interface that does not depend on the wave speed.
  typedef struct packed {
    logic                      dry;
    logic [31:0]               abs_ul;
    logic [31:0]               abs_ur;
    logic signed [MASS_W-1:0]  mass_base;
    logic signed [32:0]        diff_h;
    logic signed [DIFF_W-1:0]  diff_q;
    logic signed [DIFF_W-1:0]  diff_t;
    logic signed [SUM_W-1:0]   norm_base;
    logic signed [SUM_W-1:0]   tang_base;
  } front_t;

endpackage

[hdl/swrf_sqrt.sv]
module swrf_sqrt #(
  parameter int STEPS = swrf_pkg::SQRT_STEPS
) (
  input  logic                            clk,
  input  logic [swrf_pkg::RADICAND_W-1:0] radicand,
  output logic [swrf_pkg::ROOT_W-1:0]     root
);

  localparam int RW     = swrf_pkg::RADICAND_W;
  localparam int QW     = swrf_pkg::ROOT_W;
  localparam int STAGES = QW / STEPS;

  typedef struct packed {
    logic [RW-1:0] x;
    logic [QW+3:0] r;
    logic [QW-1:0] q;
  } sq_t;

  sq_t st [STAGES];

  // Restoring digit recurrence, two radicand bits per step, most significant first.
  function automatic sq_t sq_steps(input sq_t a);
    sq_t           b;
    logic [QW+3:0] trial;
    b = a;
    for (int j = 0; j < STEPS; j++) begin
      b.r   = {b.r[QW+1:0], b.x[RW-1:RW-2]};
      b.x   = {b.x[RW-3:0], 2'b00};
      trial = {2'b00, b.q, 2'b01};
      if (b.r >= trial) begin
        b.r = b.r - trial;
        b.q = {b.q[QW-2:0], 1'b1};
      end else begin
        b.q = {b.q[QW-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    st[0] <= sq_steps('{x: radicand, r: '0, q: '0});
    for (int k = 1; k < STAGES; k++) begin
      st[k] <= sq_steps(st[k-1]);
    end
  end

  assign root = st[STAGES-1].q;

endmodule

[hdl/swrf_front.sv]
module swrf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  swrf_pkg::request_t              request,
  input  logic [23:0]                     gravity,
  input  logic [23:0]                     half_gravity,
  output logic [swrf_pkg::RADICAND_W-1:0] radicand_l,
  output logic [swrf_pkg::RADICAND_W-1:0] radicand_r,
  output logic                            out_valid,
  output swrf_pkg::front_t                front
);

  localparam int MW = swrf_pkg::MASS_W;
  localparam int DW = swrf_pkg::DIFF_W;
  localparam int SW = swrf_pkg::SUM_W;

  // Stage 1: single products of the inputs.
  logic v1, dry1;
  logic signed [31:0] hl1, hr1, ul1, ur1, vl1, vr1;
  logic signed [63:0] ql1, qr1, tl1, tr1, hhl1, hhr1;
  logic [31:0] aul1, aur1;

  logic [30:0] hcl, hcr;
  logic [54:0] gl_c, gr_c;
  logic signed [63:0] ql_c, qr_c, tl_c, tr_c, hhl_c, hhr_c;
  logic [31:0] aul_c, aur_c;

  assign hcl   = request.left_depth[31] ? '0 : request.left_depth[30:0];
  assign hcr   = request.right_depth[31] ? '0 : request.right_depth[30:0];
  assign gl_c  = gravity * hcl;
  assign gr_c  = gravity * hcr;
  assign ql_c  = request.left_depth * request.left_vel_normal;
  assign qr_c  = request.right_depth * request.right_vel_normal;
  assign tl_c  = request.left_depth * request.left_vel_tangent;
  assign tr_c  = request.right_depth * request.right_vel_tangent;
  assign hhl_c = request.left_depth * request.left_depth;
  assign hhr_c = request.right_depth * request.right_depth;
  assign aul_c = request.left_vel_normal[31] ? ~request.left_vel_normal + 32'd1
                                             : request.left_vel_normal;
  assign aur_c = request.right_vel_normal[31] ? ~request.right_vel_normal + 32'd1
                                              : request.right_vel_normal;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    dry1 <= (request.left_depth[31] || request.left_depth == '0) &&
            (request.right_depth[31] || request.right_depth == '0);
    hl1 <= request.left_depth;
    hr1 <= request.right_depth;
    ul1 <= request.left_vel_normal;
    ur1 <= request.right_vel_normal;
    vl1 <= request.left_vel_tangent;
    vr1 <= request.right_vel_tangent;
    ql1 <= ql_c;
    qr1 <= qr_c;
    tl1 <= tl_c;
    tr1 <= tr_c;
    hhl1 <= hhl_c;
    hhr1 <= hhr_c;
    aul1 <= aul_c;
    aur1 <= aur_c;
    radicand_l <= {1'b0, gl_c};
    radicand_r <= {1'b0, gr_c};
  end

  // Stage 2: 64-bit by 32-bit products split into two partial products each.
  logic signed [63:0] xs [6];
  logic signed [32:0] ys [6];
  logic signed [65:0] pl_c [6];
  logic signed [64:0] ph_c [6];

  always_comb begin
    xs[0] = ql1;  ys[0] = 33'(ul1);
    xs[1] = qr1;  ys[1] = 33'(ur1);
    xs[2] = ql1;  ys[2] = 33'(vl1);
    xs[3] = qr1;  ys[3] = 33'(vr1);
    xs[4] = hhl1; ys[4] = $signed({9'b0, half_gravity});
    xs[5] = hhr1; ys[5] = $signed({9'b0, half_gravity});
    for (int k = 0; k < 6; k++) begin
      pl_c[k] = $signed({1'b0, xs[k][31:0]}) * ys[k];
      ph_c[k] = $signed(xs[k][63:32]) * ys[k];
    end
  end

  logic v2, dry2;
  logic signed [65:0] pl2 [6];
  logic signed [64:0] ph2 [6];
  logic signed [63:0] ql2, qr2, tl2, tr2;
  logic signed [31:0] hl2, hr2;
  logic [31:0] aul2, aur2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dry2 <= dry1;
    pl2 <= pl_c;
    ph2 <= ph_c;
    ql2 <= ql1;
    qr2 <= qr1;
    tl2 <= tl1;
    tr2 <= tr1;
    hl2 <= hl1;
    hr2 <= hr1;
    aul2 <= aul1;
    aur2 <= aur1;
  end

  // Stage 3: join partial products, form the differences.
  logic v3, dry3;
  logic signed [96:0] prod3 [6];
  logic signed [MW-1:0] mass3;
  logic signed [DW-1:0] dq3, dt3;
  logic signed [32:0] dh3;
  logic [31:0] aul3, aur3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int k = 0; k < 6; k++) begin
      prod3[k] <= (97'(ph2[k]) <<< 32) + 97'(pl2[k]);
    end
    dry3  <= dry2;
    mass3 <= MW'(ql2) + MW'(qr2);
    dq3   <= DW'(qr2) - DW'(ql2);
    dt3   <= DW'(tr2) - DW'(tl2);
    dh3   <= 33'(hr2) - 33'(hl2);
    aul3  <= aul2;
    aur3  <= aur2;
  end

  // Stage 4: central sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    front.dry       <= dry3;
    front.abs_ul    <= aul3;
    front.abs_ur    <= aur3;
    front.mass_base <= mass3;
    front.diff_h    <= dh3;
    front.diff_q    <= dq3;
    front.diff_t    <= dt3;
    front.norm_base <= SW'(prod3[0]) + SW'(prod3[1]) + SW'(prod3[4]) + SW'(prod3[5]);
    front.tang_base <= SW'(prod3[2]) + SW'(prod3[3]);
  end

endmodule

[hdl/swrf_back.sv]
module swrf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  swrf_pkg::front_t            front,
  input  logic [swrf_pkg::ROOT_W-1:0] root_l,
  input  logic [swrf_pkg::ROOT_W-1:0] root_r,
  output logic                        done,
  output swrf_pkg::result_t           result
);

  localparam int SW        = swrf_pkg::SUM_W;
  localparam int MASS_DROP = 17;
  localparam int MOM_DROP  = 33;

  // Round to nearest with ties up after dropping n bits, then clamp to 48 bits.
  function automatic logic [47:0] round_sat(input logic signed [SW-1:0] s,
                                            input int unsigned n);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] q;
    t = s + (SW'(1) <<< (n - 1));
    q = t >>> n;
    if (q[SW-1:47] == '0 || q[SW-1:47] == '1) begin
      return q[47:0];
    end
    return q[SW-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  endfunction

  // Stage 1: wave speed.
  logic [32:0] sl_c, sr_c;
  logic v1;
  logic [32:0] c1;
  swrf_pkg::front_t f1;

  assign sl_c = 33'(front.abs_ul) + 33'(root_l);
  assign sr_c = 33'(front.abs_ur) + 33'(root_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    c1 <= (sl_c > sr_c) ? sl_c : sr_c;
    f1 <= front;
  end

  // Stage 2: products with the wave speed.
  logic signed [33:0] cs;
  assign cs = $signed({1'b0, c1});

  logic v2, dry2;
  logic [32:0] c2;
  logic signed [66:0] dhc2, pql2, pqh2, ptl2, pth2;
  logic signed [swrf_pkg::MASS_W-1:0] mass2;
  logic signed [SW-1:0] norm2, tang2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dry2  <= f1.dry;
    c2    <= c1;
    dhc2  <= f1.diff_h * cs;
    pql2  <= $signed({1'b0, f1.diff_q[31:0]}) * cs;
    pqh2  <= $signed(f1.diff_q[64:32]) * cs;
    ptl2  <= $signed({1'b0, f1.diff_t[31:0]}) * cs;
    pth2  <= $signed(f1.diff_t[64:32]) * cs;
    mass2 <= f1.mass_base;
    norm2 <= f1.norm_base;
    tang2 <= f1.tang_base;
  end

  // Stage 3: exact doubled fluxes.
  logic v3, dry3;
  logic [32:0] c3;
  logic signed [SW-1:0] mass3, norm3, tang3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    dry3  <= dry2;
    c3    <= c2;
    mass3 <= SW'(mass2) - SW'(dhc2);
    norm3 <= norm2 - ((SW'(pqh2) <<< 32) + SW'(pql2));
    tang3 <= tang2 - ((SW'(pth2) <<< 32) + SW'(ptl2));
  end

  // Stage 4: rounding, saturation and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    if (dry3) begin
      result <= '0;
    end else begin
      result.mass_flux             <= round_sat(mass3, MASS_DROP);
      result.normal_momentum_flux  <= round_sat(norm3, MOM_DROP);
      result.tangent_momentum_flux <= round_sat(tang3, MOM_DROP);
      result.max_wave_speed        <= c3[32] ? '1 : c3[31:0];
    end
  end

endmodule

[hdl/shallow_water_rusanov_flux_unit.sv]
// Rusanov flux unit for the 2D shallow-water equations.
// A request (left and right depth, normal and tangential velocity, Q16.16)
// is taken at each rising edge where start is high and busy is low. busy
// stays low, so a new request may be issued every cycle.
// Each request gives one result (three Q32.16 fluxes and the maximum wave
// speed) on result, valid for one cycle while done is high. The pipelined
// square root of g*h, SQRT_STEPS root bits per stage, runs beside the flux
// products of swrf_front; the four stages of swrf_back then form the
// wave-speed products, sums and rounding. Results come out in request order.
// The receiver cannot hold results off; done is a one-cycle strobe.
// The APB port holds gravity (paddr 0) and half_gravity (paddr 4), both
// unsigned Q8.16; write them only while no request is in flight.
// Synchronous reset empties the pipeline, so no stale done follows it, and
// restores the register defaults.
module shallow_water_rusanov_flux_unit #(
  parameter int SQRT_STEPS = swrf_pkg::SQRT_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  swrf_pkg::request_t request,
  output logic               done,
  output swrf_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int STAGES = swrf_pkg::ROOT_W / SQRT_STEPS;
  localparam int DLY    = STAGES - 3;
  localparam int LAT    = STAGES + 5;

  logic [23:0] gravity, half_gravity;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity      <= 24'(swrf_pkg::GRAVITY_RESET);
      half_gravity <= 24'(swrf_pkg::HALF_GRAVITY_RESET);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        swrf_pkg::REG_GRAVITY:      gravity      <= pwdata[23:0];
        swrf_pkg::REG_HALF_GRAVITY: half_gravity <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      swrf_pkg::REG_GRAVITY:      prdata = {8'b0, gravity};
      swrf_pkg::REG_HALF_GRAVITY: prdata = {8'b0, half_gravity};
      default:                    prdata = '0;
    endcase
  end

  logic [swrf_pkg::RADICAND_W-1:0] radicand_l, radicand_r;
  logic [swrf_pkg::ROOT_W-1:0]     root_l, root_r;
  logic                            front_valid;
  swrf_pkg::front_t                front;

  swrf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .request      (request),
    .gravity      (gravity),
    .half_gravity (half_gravity),
    .radicand_l   (radicand_l),
    .radicand_r   (radicand_r),
    .out_valid    (front_valid),
    .front        (front)
  );

  swrf_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt_l (
    .clk      (clk),
    .radicand (radicand_l),
    .root     (root_l)
  );

  swrf_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt_r (
    .clk      (clk),
    .radicand (radicand_r),
    .root     (root_r)
  );

  // Hold the flux terms until the roots are out.
  swrf_pkg::front_t dly   [DLY];
  logic             dly_v [DLY];

  always_ff @(posedge clk) begin
    dly[0] <= front;
    for (int i = 1; i < DLY; i++) begin
      dly[i] <= dly[i-1];
    end
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        dly_v[i] <= 1'b0;
      end
    end else begin
      dly_v[0] <= front_valid;
      for (int i = 1; i < DLY; i++) begin
        dly_v[i] <= dly_v[i-1];
      end
    end
  end

  swrf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dly_v[DLY-1]),
    .front    (dly[DLY-1]),
    .root_l   (root_l),
    .root_r   (root_r),
    .done     (done),
    .result   (result)
  );

`ifndef ASSERT_OFF
  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not produce a result on time");

  a_result_had_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_gravity_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == swrf_pkg::REG_GRAVITY)
      |=> gravity == $past(pwdata[23:0]))
    else $error("gravity register write lost");
`endif

endmodule
